FILE: hw/rtl/adcdp_pkg.sv
// Package for the audio DAC clock divider planner.
// Holds the request, result and queue entry types and the fixed plan constants.
// No dependencies.
package adcdp_pkg;

    localparam int RATE_W   = 19;
    localparam int BITS_W   = 6;
    localparam int BCK_W    = 26;
    localparam int MRATE_W  = 22;
    localparam int DIV_W    = 27;
    localparam int QUO_W    = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    localparam logic [BCK_W-1:0] BCK_MIN     = 26'd1000000;
    localparam logic [BCK_W-1:0] BCK_MAX     = 26'd50000000;
    localparam logic [BCK_W-1:0] BCK_P3_MIN  = 26'd1536000;
    localparam logic [BCK_W-1:0] BCK_P2_MIN  = 26'd12288000;
    localparam logic [BCK_W-1:0] RECIP_3     = 26'd44739243;

    localparam logic [RATE_W-1:0] RATE_11K025 = 19'd11025;
    localparam logic [RATE_W-1:0] RATE_16K    = 19'd16000;
    localparam logic [RATE_W-1:0] RATE_22K05  = 19'd22050;
    localparam logic [RATE_W-1:0] RATE_32K    = 19'd32000;
    localparam logic [RATE_W-1:0] RATE_44K1   = 19'd44100;
    localparam logic [RATE_W-1:0] RATE_48K    = 19'd48000;
    localparam logic [RATE_W-1:0] RATE_96K    = 19'd96000;
    localparam logic [RATE_W-1:0] RATE_192K   = 19'd192000;

    localparam logic [BITS_W-1:0] BITS_24 = 6'd24;
    localparam logic [BITS_W-1:0] BITS_32 = 6'd32;

    localparam logic [DIV_W-1:0] NUM_98M304 = 27'd98304000;
    localparam logic [DIV_W-1:0] NUM_90M3168 = 27'd90316800;
    localparam logic [DIV_W-1:0] NUM_384K   = 27'd384000;

    localparam logic [1:0] P_CODE_1 = 2'd0;
    localparam logic [1:0] P_CODE_2 = 2'd1;
    localparam logic [1:0] P_CODE_3 = 2'd2;

    localparam logic [2:0] NMAC_CODE_2 = 3'd1;
    localparam logic [2:0] NMAC_CODE_3 = 3'd2;
    localparam logic [2:0] NMAC_CODE_6 = 3'd5;

    localparam logic [1:0] SPEED_NORMAL = 2'd0;
    localparam logic [1:0] SPEED_DOUBLE = 2'd1;
    localparam logic [1:0] SPEED_QUAD   = 2'd2;
    localparam logic [1:0] SPEED_OCTAL  = 2'd3;

    localparam logic [1:0] WORD_CODE_16 = 2'd0;
    localparam logic [1:0] WORD_CODE_24 = 2'd2;
    localparam logic [1:0] WORD_CODE_32 = 2'd3;

    localparam logic       PLL_R_CODE   = 1'b1;
    localparam logic [3:0] DAC_DIV_CODE = 4'd15;
    localparam logic [1:0] PUMP_DIV_CODE = 2'd3;
    localparam logic [7:0] OSR_FAMILY_CODE = 8'd7;
    localparam logic [15:0] IDAC_FAMILY = 16'd1024;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate_hz;
        logic [BITS_W-1:0] bits_per_sample;
    } adcdp_req_t;

    typedef struct packed {
        logic        plan_ok;
        logic [1:0]  pll_p_code;
        logic [6:0]  pll_j_value;
        logic        pll_r_code;
        logic [2:0]  dsp_div_code;
        logic [3:0]  dac_div_code;
        logic [1:0]  pump_div_code;
        logic [7:0]  osr_div_code;
        logic [15:0] dsp_cycles_per_sample;
        logic [1:0]  speed_mode;
        logic [1:0]  word_length_code;
    } adcdp_res_t;

    typedef struct packed {
        logic               ok;
        logic               family_44k1;
        logic [1:0]         p_code;
        logic [2:0]         nmac_code;
        logic [BCK_W-1:0]   bck;
        logic [RATE_W-1:0]  rate;
        logic [MRATE_W-1:0] mrate;
        logic [1:0]         speed;
        logic [1:0]         wcode;
    } adcdp_entry_t;

endpackage

FILE: hw/rtl/adcdp_front.sv
// Front end of the clock planner: accepts requests and classifies them.
// Forms the bit clock, checks limits and picks the plan codes; uses adcdp_pkg.
module adcdp_front
    import adcdp_pkg::*;
(
    input  logic         start,
    input  adcdp_req_t   request,
    input  logic         queue_full,
    output logic         busy,
    output logic         push,
    output adcdp_entry_t entry
);

    logic [BCK_W-1:0]   rate_bits;
    logic [BCK_W-1:0]   bck;
    logic [RATE_W-1:0]  rate;
    logic [BITS_W-1:0]  bits;
    logic               family;
    logic               reject_24;
    logic [2:0]         nmac_code;
    logic [2:0]         nmac;

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        rate = request.sample_rate_hz;
        bits = request.bits_per_sample;
        rate_bits = {7'b0, rate} * {20'b0, bits};
        bck = {rate_bits[BCK_W-2:0], 1'b0};
        family = (rate == RATE_11K025) || (rate == RATE_22K05) || (rate == RATE_44K1);
        reject_24 = ((rate == RATE_44K1) || (rate == RATE_48K)) && (bits == BITS_24);

        if (family)
            nmac_code = NMAC_CODE_2;
        else if (rate == RATE_16K)
            nmac_code = NMAC_CODE_6;
        else if (rate == RATE_32K)
            nmac_code = NMAC_CODE_3;
        else
            nmac_code = NMAC_CODE_2;
        nmac = nmac_code + 3'd1;

        entry.ok = (bck >= BCK_MIN) && (bck <= BCK_MAX) && !reject_24;
        entry.family_44k1 = family;
        if (family)
            entry.p_code = P_CODE_1;
        else if ((bits == BITS_24) && (bck > BCK_P3_MIN))
            entry.p_code = P_CODE_3;
        else if (bck > BCK_P2_MIN)
            entry.p_code = P_CODE_2;
        else
            entry.p_code = P_CODE_1;
        entry.nmac_code = nmac_code;
        entry.bck = bck;
        entry.rate = rate;
        entry.mrate = {3'b0, rate} * {19'b0, nmac};

        if (rate <= RATE_48K)
            entry.speed = SPEED_NORMAL;
        else if (rate <= RATE_96K)
            entry.speed = SPEED_DOUBLE;
        else if (rate <= RATE_192K)
            entry.speed = SPEED_QUAD;
        else
            entry.speed = SPEED_OCTAL;

        if (bits == BITS_24)
            entry.wcode = WORD_CODE_24;
        else if (bits == BITS_32)
            entry.wcode = WORD_CODE_32;
        else
            entry.wcode = WORD_CODE_16;
    end

endmodule

FILE: hw/rtl/adcdp_queue.sv
// Two-entry queue of classified requests between front and back end.
// Uses adcdp_pkg for the entry type and depth.
module adcdp_queue
    import adcdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  adcdp_entry_t push_data,
    input  logic         pop,
    output adcdp_entry_t pop_data,
    output logic         full,
    output logic         empty
);

    adcdp_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_PTR_W:0]    count_reg;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [QUEUE_PTR_W:0]    count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hw/rtl/adcdp_divider.sv
// Restoring divider giving a 16-bit quotient, one quotient bit per cycle.
// Uses adcdp_pkg for operand widths.
module adcdp_divider
    import adcdp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quotient
);

    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W+QUO_W-2:0]   den_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [3:0]               cnt_reg;
    logic                     busy_reg;
    logic [DIV_W-1:0]         rem_next;
    logic [DIV_W+QUO_W-2:0]   den_next;
    logic [QUO_W-1:0]         quo_next;
    logic [3:0]               cnt_next;
    logic                     busy_next;
    logic                     fits;

    assign busy = busy_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        fits = ({{(QUO_W-1){1'b0}}, rem_reg} >= den_reg);
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = dividend;
            den_next = {divisor, {(QUO_W-1){1'b0}}};
            quo_next = '0;
            cnt_next = 4'(QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = rem_reg - den_reg[DIV_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: hw/rtl/adcdp_back.sv
// Back end of the clock planner: takes classified requests from the queue,
// runs the PLL and divider quotients and drives the result strobe.
// Uses adcdp_pkg and adcdp_divider.
module adcdp_back
    import adcdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         queue_empty,
    input  adcdp_entry_t queue_data,
    output logic         pop,
    output logic         done,
    output adcdp_res_t   result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    adcdp_entry_t       entry_reg;
    logic [BCK_W-1:0]   q_reg;
    logic [BCK_W-1:0]   q_next;
    logic               done_reg;
    logic               done_next;
    adcdp_res_t         result_reg;
    adcdp_res_t         result_next;
    logic [2*BCK_W-1:0] third_prod;
    logic               div_start;
    logic               j_busy;
    logic               osr_busy;
    logic               idac_busy;
    logic [QUO_W-1:0]   j_quo;
    logic [QUO_W-1:0]   osr_quo;
    logic [QUO_W-1:0]   idac_quo;
    logic [DIV_W-1:0]   j_num;

    assign pop = (state_reg == ST_IDLE) && !queue_empty;
    assign div_start = (state_reg == ST_START);
    assign done = done_reg;
    assign result = result_reg;
    assign j_num = entry_reg.family_44k1 ? NUM_90M3168 : NUM_98M304;

    adcdp_divider u_j_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (j_num),
        .divisor  ({q_reg, 1'b0}),
        .busy     (j_busy),
        .quotient (j_quo)
    );

    adcdp_divider u_osr_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (NUM_384K),
        .divisor  ({8'b0, entry_reg.rate}),
        .busy     (osr_busy),
        .quotient (osr_quo)
    );

    adcdp_divider u_idac_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (NUM_98M304),
        .divisor  ({5'b0, entry_reg.mrate}),
        .busy     (idac_busy),
        .quotient (idac_quo)
    );

    always_comb
    begin
        third_prod = {{BCK_W{1'b0}}, entry_reg.bck} * {{BCK_W{1'b0}}, RECIP_3};
        case (entry_reg.p_code)
            P_CODE_2: q_next = entry_reg.bck >> 1;
            P_CODE_3: q_next = {1'b0, third_prod[2*BCK_W-1:BCK_W+1]};
            default:  q_next = entry_reg.bck;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!j_busy && !osr_busy && !idac_busy)
                begin
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                    result_next = '0;
                    if (entry_reg.ok)
                    begin
                        result_next.plan_ok = 1'b1;
                        result_next.pll_p_code = entry_reg.p_code;
                        result_next.pll_j_value = j_quo[6:0];
                        result_next.pll_r_code = PLL_R_CODE;
                        result_next.dsp_div_code = entry_reg.nmac_code;
                        result_next.dac_div_code = DAC_DIV_CODE;
                        result_next.pump_div_code = PUMP_DIV_CODE;
                        result_next.osr_div_code = entry_reg.family_44k1 ?
                            OSR_FAMILY_CODE : osr_quo[7:0] - 8'd1;
                        result_next.dsp_cycles_per_sample = entry_reg.family_44k1 ?
                            IDAC_FAMILY : idac_quo;
                        result_next.speed_mode = entry_reg.speed;
                        result_next.word_length_code = entry_reg.wcode;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= queue_data;
        if (state_reg == ST_PREP)
            q_reg <= q_next;
        result_reg <= result_next;
    end

endmodule

FILE: hw/rtl/audio_dac_clock_divider_planner_top.sv
// Top level of the audio DAC clock divider planner.
// Connects adcdp_front, adcdp_queue and adcdp_back; uses adcdp_pkg.
//
// A request (sample rate and word length) is taken at a rising edge where
// start is high and busy is low. The front end classifies it in that cycle
// and writes it into a two-entry queue, so busy rises only when the queue
// is full. The back end takes one request at a time from the queue and
// computes the PLL J value, the oversampling divider and dsp_cycles_per_sample
// with three restoring dividers running side by side. The back end
// pops a request in its idle state, registers the PLL divider input in the
// prep state, starts the dividers and waits; done pulses once all three are
// finished. Each result is on the result port from the cycle in which done
// is high until the next result; the receiver must take it then, since it
// cannot stall the block. Requests that fail the bit-clock or format checks
// still give one result with plan_ok low and all other fields zero.
// Reset empties the queue, returns the back end to idle and drops done.
module audio_dac_clock_divider_planner_top
    import adcdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  adcdp_req_t request,
    output logic       done,
    output adcdp_res_t result
);

    logic         push;
    adcdp_entry_t push_entry;
    logic         queue_full;
    logic         queue_empty;
    logic         pop;
    adcdp_entry_t pop_entry;

    adcdp_front u_front (
        .start      (start),
        .request    (request),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .entry      (push_entry)
    );

    adcdp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    adcdp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_entry),
        .pop         (pop),
        .done        (done),
        .result      (result)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for audio_dac_clock_divider_planner_top.
// Sends directed and random stream format requests and checks every clock plan against a
// built-in predictor. Depends on adcdp_pkg and the planner RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import adcdp_pkg::*;

    localparam int unsigned MAX_GAP      = 13;
    localparam int unsigned RANDOM_COUNT = 650;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RATE_MAX     = (1 << RATE_W) - 1;

    typedef struct {
        adcdp_req_t  req;
        int unsigned gap;
        bit          drain;
    } format_request_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    adcdp_req_t request = '0;
    logic       done;
    adcdp_res_t result;

    format_request_t pending_formats[$];
    adcdp_res_t      expected_plans[$];
    int unsigned     idle_cycles = 0;
    int unsigned     plans_outstanding = 0;
    int unsigned     requests_taken = 0;
    int unsigned     requests_total = 0;
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;

    audio_dac_clock_divider_planner_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic adcdp_res_t plan_clock_dividers(adcdp_req_t req);
        adcdp_res_t        plan;
        longint unsigned   rate;
        longint unsigned   bits;
        longint unsigned   bck;
        longint unsigned   p_div;
        longint unsigned   nmac_div;
        plan = '0;
        rate = req.sample_rate_hz;
        bits = req.bits_per_sample;
        bck  = rate * bits * 2;
        if (bck < BCK_MIN || bck > BCK_MAX)
        begin
            return plan;
        end
        if ((rate == RATE_44K1 || rate == RATE_48K) && bits == BITS_24)
        begin
            return plan;
        end
        if (rate == RATE_11K025 || rate == RATE_22K05 || rate == RATE_44K1)
        begin
            plan.pll_p_code            = P_CODE_1;
            plan.pll_j_value           = 7'(NUM_90M3168 / bck / 2);
            plan.dsp_div_code          = NMAC_CODE_2;
            plan.osr_div_code          = OSR_FAMILY_CODE;
            plan.dsp_cycles_per_sample = IDAC_FAMILY;
        end
        else
        begin
            if (bits == BITS_24 && bck > BCK_P3_MIN)
            begin
                p_div = 3;
                plan.pll_p_code = P_CODE_3;
            end
            else if (bck > BCK_P2_MIN)
            begin
                p_div = 2;
                plan.pll_p_code = P_CODE_2;
            end
            else
            begin
                p_div = 1;
                plan.pll_p_code = P_CODE_1;
            end
            plan.pll_j_value = 7'(NUM_98M304 / (bck / p_div) / 2);
            if (rate == RATE_16K)
            begin
                nmac_div = 6;
                plan.dsp_div_code = NMAC_CODE_6;
            end
            else if (rate == RATE_32K)
            begin
                nmac_div = 3;
                plan.dsp_div_code = NMAC_CODE_3;
            end
            else
            begin
                nmac_div = 2;
                plan.dsp_div_code = NMAC_CODE_2;
            end
            plan.osr_div_code          = 8'(NUM_384K / rate - 1);
            plan.dsp_cycles_per_sample = 16'(NUM_98M304 / nmac_div / rate);
        end
        if (rate <= RATE_48K)
        begin
            plan.speed_mode = SPEED_NORMAL;
        end
        else if (rate <= RATE_96K)
        begin
            plan.speed_mode = SPEED_DOUBLE;
        end
        else if (rate <= RATE_192K)
        begin
            plan.speed_mode = SPEED_QUAD;
        end
        else
        begin
            plan.speed_mode = SPEED_OCTAL;
        end
        if (bits == BITS_24)
        begin
            plan.word_length_code = WORD_CODE_24;
        end
        else if (bits == BITS_32)
        begin
            plan.word_length_code = WORD_CODE_32;
        end
        else
        begin
            plan.word_length_code = WORD_CODE_16;
        end
        plan.plan_ok       = 1'b1;
        plan.pll_r_code    = PLL_R_CODE;
        plan.dac_div_code  = DAC_DIV_CODE;
        plan.pump_div_code = PUMP_DIV_CODE;
        return plan;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic compare_plan(input adcdp_res_t got, input adcdp_res_t want);
        check_field("plan_ok", got.plan_ok, want.plan_ok);
        check_field("pll_p_code", got.pll_p_code, want.pll_p_code);
        check_field("pll_j_value", got.pll_j_value, want.pll_j_value);
        check_field("pll_r_code", got.pll_r_code, want.pll_r_code);
        check_field("dsp_div_code", got.dsp_div_code, want.dsp_div_code);
        check_field("dac_div_code", got.dac_div_code, want.dac_div_code);
        check_field("pump_div_code", got.pump_div_code, want.pump_div_code);
        check_field("osr_div_code", got.osr_div_code, want.osr_div_code);
        check_field("dsp_cycles_per_sample", got.dsp_cycles_per_sample,
                    want.dsp_cycles_per_sample);
        check_field("speed_mode", got.speed_mode, want.speed_mode);
        check_field("word_length_code", got.word_length_code, want.word_length_code);
    endtask

    task automatic queue_format(input int unsigned rate, input int unsigned bits,
                                input int unsigned gap, input bit drain);
        format_request_t item;
        item.req.sample_rate_hz  = RATE_W'(rate);
        item.req.bits_per_sample = BITS_W'(bits);
        item.gap   = gap;
        item.drain = drain;
        pending_formats.push_back(item);
        requests_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            request     <= '0;
            idle_cycles <= 0;
        end
        else if (!start || !busy)
        begin
            if (pending_formats.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (idle_cycles < pending_formats[0].gap ||
                     (pending_formats[0].drain && (start || plans_outstanding != 0)))
            begin
                start       <= 1'b0;
                idle_cycles <= idle_cycles + 1;
            end
            else
            begin
                start       <= 1'b1;
                request     <= pending_formats[0].req;
                idle_cycles <= 0;
                void'(pending_formats.pop_front());
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        adcdp_res_t want;
        if (!rst_n)
        begin
            plans_outstanding <= 0;
            requests_taken    <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_plans.push_back(plan_clock_dividers(request));
                requests_taken <= requests_taken + 1;
            end
            if (done)
            begin
                if (expected_plans.size() == 0)
                begin
                    report_mismatch("result with no request waiting");
                end
                else
                begin
                    want = expected_plans.pop_front();
                    compare_plan(result, want);
                end
            end
            plans_outstanding <= expected_plans.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned std_rates[13] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
                                       88200, 96000, 176400, 192000, 352800, 384000};
        int unsigned std_bits[3] = '{16, 24, 32};
        int unsigned rate;
        int unsigned bits;
        int unsigned lo;
        int unsigned hi;
        int unsigned gap;
        bit          quiet;
        queue_format(0, 0, 0, 1'b0);
        queue_format(RATE_MAX, 63, 0, 1'b0);
        queue_format(44100, 24, 0, 1'b0);
        queue_format(48000, 24, 3, 1'b0);
        queue_format(11025, 16, 0, 1'b0);
        queue_format(22050, 32, 0, 1'b0);
        queue_format(44100, 16, 0, 1'b0);
        queue_format(44100, 32, 7, 1'b0);
        queue_format(16000, 32, 0, 1'b0);
        queue_format(32000, 16, 0, 1'b0);
        queue_format(32000, 24, 0, 1'b0);
        queue_format(48000, 16, 13, 1'b1);
        queue_format(96000, 24, 0, 1'b0);
        queue_format(192000, 32, 0, 1'b0);
        queue_format(192000, 24, 2, 1'b0);
        queue_format(384000, 32, 0, 1'b0);
        queue_format(400000, 16, 0, 1'b0);
        queue_format(RATE_MAX, 32, 0, 1'b0);
        queue_format(31250, 16, 5, 1'b0);
        queue_format(31249, 16, 0, 1'b0);
        queue_format(500000, 50, 0, 1'b0);
        queue_format(500001, 50, 0, 1'b0);
        queue_format(500000, 1, 1, 1'b0);
        queue_format(48001, 20, 0, 1'b0);
        queue_format(192001, 17, 0, 1'b0);
        for (int unsigned n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 50 == 0)
            begin
                quiet = $urandom_range(0, 2) == 0;
            end
            case ($urandom_range(0, 7))
                0, 1, 2, 3:
                begin
                    rate = std_rates[$urandom_range(0, 12)];
                    bits = std_bits[$urandom_range(0, 2)];
                end
                4, 5:
                begin
                    bits = $urandom_range(1, 63);
                    lo   = (1000000 + 2 * bits - 1) / (2 * bits);
                    hi   = 50000000 / (2 * bits);
                    if (hi > RATE_MAX)
                    begin
                        hi = RATE_MAX;
                    end
                    rate = $urandom_range(lo, hi);
                end
                default:
                begin
                    rate = $urandom_range(0, RATE_MAX);
                    bits = $urandom_range(0, 63);
                end
            endcase
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            queue_format(rate, bits, gap, n % 150 == 75);
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (requests_taken != requests_total || plans_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (expected_plans.size() != 0)
        begin
            void'(expected_plans.pop_front());
            report_mismatch("expected result never arrived");
        end
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: audio_dac_clock_divider_planner_top.f
hw/rtl/adcdp_pkg.sv
hw/rtl/adcdp_front.sv
hw/rtl/adcdp_queue.sv
hw/rtl/adcdp_divider.sv
hw/rtl/adcdp_back.sv
hw/rtl/audio_dac_clock_divider_planner_top.sv
tb/sv/testbench.sv
